[design/pow_nonce_search_macros.svh]
// assertion macros for the nonce search block
// used by pow_nonce_search.sv, no other dependencies
`ifndef POW_NONCE_SEARCH_MACROS_SVH
`define POW_NONCE_SEARCH_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PNS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pow_nonce_search check failed");

// antecedent implies consequent in the next cycle
`define PNS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pow_nonce_search check failed");

`endif

[design/pns_pkg.sv]
// shared types, constants and sha-256 helper functions for the nonce search
// no dependencies
package pns_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_START2,
    ST_MUL,
    ST_OUT
  } pns_state_t;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_MINE = 1'b1;
  localparam logic [1:0] CFG_DIFFICULTY = 2'd0;
  localparam logic [1:0] CFG_MAX_ATTEMPTS = 2'd1;
  localparam int unsigned NUM_HDR = 10;

  typedef logic [31:0] word_t;

  localparam word_t INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t ssig0(input word_t x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

[design/pow_nonce_search.sv]
// proof-of-work nonce search top level: header store, sha-256 round unit,
// bit-serial difficulty check and result sequencer; uses pns_pkg and the macro header
//
// Load beats (tuser 0) store one of ten 64-bit header words and give no result.
// A mine beat (tuser 1) first compresses the fixed first block (height, parent,
// merkle 0..2) into a midstate, then tries nonces 0, 1, 2, ... For each nonce
// one sha-256 round unit runs the 64 rounds of the second block one round per
// cycle, and a shift-add unit then checks h * difficulty < 2^64 one difficulty
// bit per cycle (same as floor((2^64-1)/h) >= difficulty). Each nonce goes through
// setup, 64 rounds, fold and 64 check steps; a search first forms the midstate (64
// rounds and fold), then makes one such pass per attempt and a give-up check when
// no nonce passes, and then gives its result beats, held while the output stalls.
// The block
// is not ready for input while a search runs. A hit gives four result beats
// (digest words, most significant first, tlast on the fourth); giving up after
// max_attempts gives one beat with success 0. Config writes are always taken.
`include "pow_nonce_search_macros.svh"

module pow_nonce_search import pns_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // word_index[3:0], word_value[67:4], zero fill
  input  logic         in_tuser,   // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,  // found_nonce[63:0], attempt_count[127:64],
                                   // digest_word[191:128]
  output logic [2:0]   out_tuser,  // success[0], digest_index[2:1]
  output logic         out_tlast,  // last
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  pns_state_t state_r, state_nxt;

  logic [63:0] hdr_r [NUM_HDR];
  logic [63:0] difficulty_r, max_attempts_r;

  // round unit state
  word_t       v_r [8];
  word_t       v_nxt [8];
  word_t       w_r [16];
  word_t       w_nxt [16];
  word_t       base_r [8];   // value folded in after the rounds
  word_t       base_nxt [8];
  word_t       mid_r [8];
  word_t       mid_nxt [8];
  word_t       dig_r [8];
  word_t       dig_nxt [8];
  logic [5:0]  rnd_r, rnd_nxt;
  logic        blk2_r, blk2_nxt;

  // search counters
  logic [63:0] nonce_r, nonce_nxt;
  logic [63:0] att_r, att_nxt;

  // difficulty check
  logic [63:0] acc_r, acc_nxt;
  logic        ovf_r, ovf_nxt;
  logic [5:0]  bit_r, bit_nxt;

  // result sequencing
  logic        ok_r, ok_nxt;
  logic [1:0]  oidx_r, oidx_nxt;

  logic        in_beat, out_beat;
  word_t       t1, t2, w_new;
  logic [64:0] acc_sum;
  logic [63:0] h_top;

  assign in_beat   = in_tvalid && in_tready;
  assign out_beat  = out_tvalid && out_tready;
  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);

  // one sha-256 round and one schedule step
  assign t1 = v_r[7] + bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + ROUND_K[rnd_r] + w_r[0];
  assign t2 = bsig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign w_new = w_r[0] + ssig0(w_r[1]) + w_r[9] + ssig1(w_r[14]);

  // shift-add of h by difficulty, msb first
  assign h_top   = {dig_r[0], dig_r[1]};
  assign acc_sum = {acc_r, 1'b0} + (difficulty_r[bit_r] ? {1'b0, h_top} : 65'd0);

  // output beat
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tlast  = !ok_r || (oidx_r == 2'd3);
  assign out_tuser  = {oidx_r, ok_r};
  assign out_tdata  = {ok_r ? {dig_r[{oidx_r, 1'b0}], dig_r[{oidx_r, 1'b1}]} : 64'd0,
                       att_r, ok_r ? nonce_r : 64'd0};

  always_comb begin
    state_nxt = state_r;
    v_nxt     = v_r;
    w_nxt     = w_r;
    base_nxt  = base_r;
    mid_nxt   = mid_r;
    dig_nxt   = dig_r;
    rnd_nxt   = rnd_r;
    blk2_nxt  = blk2_r;
    nonce_nxt = nonce_r;
    att_nxt   = att_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    bit_nxt   = bit_r;
    ok_nxt    = ok_r;
    oidx_nxt  = oidx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat && in_tuser == CMD_MINE) begin
          // first block: height, parent, merkle 0..2
          for (int i = 0; i < 8; i++) begin
            v_nxt[i]       = INIT_H[i];
            base_nxt[i]    = INIT_H[i];
            w_nxt[2*i]     = hdr_r[i][63:32];
            w_nxt[2*i + 1] = hdr_r[i][31:0];
          end
          rnd_nxt   = '0;
          blk2_nxt  = 1'b0;
          nonce_nxt = '0;
          att_nxt   = '0;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        for (int i = 1; i < 8; i++) v_nxt[i] = v_r[i-1];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[0] = t1 + t2;
        for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i+1];
        w_nxt[15] = w_new;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        for (int i = 0; i < 8; i++) begin
          mid_nxt[i] = blk2_r ? mid_r[i] : base_r[i] + v_r[i];
          dig_nxt[i] = base_r[i] + v_r[i];
        end
        acc_nxt   = '0;
        ovf_nxt   = 1'b0;
        bit_nxt   = 6'd63;
        state_nxt = blk2_r ? ST_MUL : ST_START2;
      end
      ST_START2: begin
        if (att_r == max_attempts_r) begin
          ok_nxt    = 1'b0;
          oidx_nxt  = '0;
          state_nxt = ST_OUT;
        end else begin
          // second block: merkle 3, timestamp, nonce, difficulty, padding
          for (int i = 0; i < 8; i++) begin
            v_nxt[i]    = mid_r[i];
            base_nxt[i] = mid_r[i];
          end
          for (int i = 0; i < 16; i++) w_nxt[i] = '0;
          w_nxt[0]  = hdr_r[8][63:32];
          w_nxt[1]  = hdr_r[8][31:0];
          w_nxt[2]  = hdr_r[9][63:32];
          w_nxt[3]  = hdr_r[9][31:0];
          w_nxt[4]  = nonce_r[63:32];
          w_nxt[5]  = nonce_r[31:0];
          w_nxt[6]  = difficulty_r[63:32];
          w_nxt[7]  = difficulty_r[31:0];
          w_nxt[8]  = 32'h80000000;
          w_nxt[15] = 32'd768;
          att_nxt   = att_r + 64'd1;
          rnd_nxt   = '0;
          blk2_nxt  = 1'b1;
          state_nxt = ST_ROUND;
        end
      end
      ST_MUL: begin
        acc_nxt = acc_sum[63:0];
        ovf_nxt = ovf_r || acc_r[63] || acc_sum[64];
        bit_nxt = bit_r - 6'd1;
        if (bit_r == 6'd0) begin
          if (h_top == 64'd0 || !(ovf_r || acc_r[63] || acc_sum[64])) begin
            ok_nxt    = 1'b1;
            oidx_nxt  = '0;
            state_nxt = ST_OUT;
          end else begin
            nonce_nxt = nonce_r + 64'd1;
            state_nxt = ST_START2;
          end
        end
      end
      ST_OUT: begin
        if (out_beat) begin
          oidx_nxt = oidx_r + 2'd1;
          if (out_tlast) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      difficulty_r   <= 64'd1;
      max_attempts_r <= '1;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DIFFICULTY:   difficulty_r   <= cfg_data;
          CFG_MAX_ATTEMPTS: max_attempts_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_beat && in_tuser == CMD_LOAD && in_tdata[3:0] < 4'(NUM_HDR)) begin
      hdr_r[in_tdata[3:0]] <= in_tdata[67:4];
    end
    v_r     <= v_nxt;
    w_r     <= w_nxt;
    base_r  <= base_nxt;
    mid_r   <= mid_nxt;
    dig_r   <= dig_nxt;
    rnd_r   <= rnd_nxt;
    blk2_r  <= blk2_nxt;
    nonce_r <= nonce_nxt;
    att_r   <= att_nxt;
    acc_r   <= acc_nxt;
    ovf_r   <= ovf_nxt;
    bit_r   <= bit_nxt;
    ok_r    <= ok_nxt;
    oidx_r  <= oidx_nxt;
  end

  `PNS_ASSERT_SAME(a_no_overlap, out_tvalid, !in_tready)
  `PNS_ASSERT_SAME(a_fail_single, out_tvalid && !out_tuser[0], out_tlast && out_tuser[2:1] == 2'd0)
  `PNS_ASSERT_NEXT(a_round_step, state_r == ST_ROUND && rnd_r != 6'd63, rnd_r == $past(rnd_r) + 6'd1)
  `PNS_ASSERT_SAME(a_att_bound, state_r == ST_OUT, att_r <= max_attempts_r)

endmodule
